// ===== rtl/core/ray_box_slab_test_assert.svh =====
// ----------------------------------------------------------------------------
// Ray box slab test assertion macros
// Concurrent assertion wrappers for the ray box slab test. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_ASSERT_SVH
`ifndef SYNTHESIS
// Assertion that is switched off while reset is high.
`define RBST_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ray_box_slab_test: assertion failed");
// Assertion that is also checked while reset is high.
`define RBST_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ray_box_slab_test: assertion failed");
`else
`define RBST_ASSERT(label, clk, rst, prop)
`define RBST_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray box slab test package
// Item types, field widths and the lane control struct shared by the ray
// box slab test modules.
// ----------------------------------------------------------------------------
package rbst_pkg;

  // Width of every input coordinate field on the ports.
  localparam int FIELD_W = 32;

  // Default number of low field bits that hold a coordinate.
  localparam int COORD_WIDTH_DEF = 32;

  // One input item: box bounds, ray origin and inverse ray direction.
  typedef struct packed {
    logic signed [FIELD_W-1:0] box_min_x;
    logic signed [FIELD_W-1:0] box_min_y;
    logic signed [FIELD_W-1:0] box_min_z;
    logic signed [FIELD_W-1:0] box_max_x;
    logic signed [FIELD_W-1:0] box_max_y;
    logic signed [FIELD_W-1:0] box_max_z;
    logic signed [FIELD_W-1:0] origin_x;
    logic signed [FIELD_W-1:0] origin_y;
    logic signed [FIELD_W-1:0] origin_z;
    logic signed [FIELD_W-1:0] inv_dir_x;
    logic signed [FIELD_W-1:0] inv_dir_y;
    logic signed [FIELD_W-1:0] inv_dir_z;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic hit;
    logic origin_inside;
  } out_item_t;

  // Load enables for the three stages inside an axis lane.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lane_en_t;

endpackage

// ===== rtl/core/rbst_axis_lane.sv =====
// ----------------------------------------------------------------------------
// Ray box slab test axis lane
// Three pipeline stages for one axis: bound differences and the inside
// check, the two plane distance products, then the near and far distance.
// ----------------------------------------------------------------------------
module rbst_axis_lane #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic signed [COORD_WIDTH-1:0]    lo,
  input  logic signed [COORD_WIDTH-1:0]    hi,
  input  logic signed [COORD_WIDTH-1:0]    org,
  input  logic signed [COORD_WIDTH-1:0]    inv,
  input  rbst_pkg::lane_en_t               en,
  output logic signed [2*COORD_WIDTH:0]    near_t,
  output logic signed [2*COORD_WIDTH:0]    far_t,
  output logic                             in_slab
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 1;

  logic signed [DW-1:0]          d_lo;
  logic signed [DW-1:0]          d_hi;
  logic signed [COORD_WIDTH-1:0] inv1;
  logic                          inside1;
  logic signed [PW-1:0]          t_lo;
  logic signed [PW-1:0]          t_hi;
  logic                          inside2;

  // Stage 1: differences from the origin to both bounds, and the slab check.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      d_lo    <= DW'(lo) - DW'(org);
      d_hi    <= DW'(hi) - DW'(org);
      inv1    <= inv;
      inside1 <= (org >= lo) && (org <= hi);
    end
  end

  // Stage 2: exact full-width plane distances.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      t_lo    <= PW'(d_lo) * PW'(inv1);
      t_hi    <= PW'(d_hi) * PW'(inv1);
      inside2 <= inside1;
    end
  end

  // Stage 3: order the two distances into near and far.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      if (t_lo < t_hi) begin
        near_t <= t_lo;
        far_t  <= t_hi;
      end else begin
        near_t <= t_hi;
        far_t  <= t_lo;
      end
      in_slab <= inside2;
    end
  end

endmodule

// ===== rtl/core/ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// Ray box slab test
// Tests a ray line against an axis-aligned box with the slab method.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless a stall holds it, and returns
// results through a six-stage pipeline: bound differences, plane distance
// products, per-axis near and far ordering, two stages that merge the axes,
// and the output register that forms the hit flag. A result that waits at the
// output stalls only the stages behind it that are full, so empty stages keep
// taking items. The test treats the ray as a line, so boxes behind the origin
// count as hits, and an origin inside the box (bounds included) always hits.
// Coordinates are the low COORD_WIDTH bits of each field, and all distances
// are exact products, so the fraction position does not affect the result.
// ----------------------------------------------------------------------------
`include "ray_box_slab_test_assert.svh"

module ray_box_slab_test #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  rbst_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output rbst_pkg::out_item_t result
);

  localparam int PW = 2 * COORD_WIDTH + 1;

  // Stage valid bits; stage six is the output register.
  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5, r6;

  rbst_pkg::lane_en_t lane_en;

  logic signed [PW-1:0] near_x, near_y, near_z;
  logic signed [PW-1:0] far_x, far_y, far_z;
  logic                 in_x, in_y, in_z;

  logic signed [PW-1:0] near01, far01, near2, far2;
  logic                 inside4;
  logic signed [PW-1:0] near5, far5;
  logic                 inside5;

  // A stage can load when it is empty or its content moves on.
  assign r6 = !result_valid || result_ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign item_ready = r1;

  assign lane_en.s1 = r1;
  assign lane_en.s2 = r2;
  assign lane_en.s3 = r3;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (r1) v1 <= item_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) result_valid <= v5;
    end
  end

  // Per-axis lanes for stages one to three.
  rbst_axis_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
    .clk     (clk),
    .lo      (item.box_min_x[COORD_WIDTH-1:0]),
    .hi      (item.box_max_x[COORD_WIDTH-1:0]),
    .org     (item.origin_x[COORD_WIDTH-1:0]),
    .inv     (item.inv_dir_x[COORD_WIDTH-1:0]),
    .en      (lane_en),
    .near_t  (near_x),
    .far_t   (far_x),
    .in_slab (in_x)
  );

  rbst_axis_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
    .clk     (clk),
    .lo      (item.box_min_y[COORD_WIDTH-1:0]),
    .hi      (item.box_max_y[COORD_WIDTH-1:0]),
    .org     (item.origin_y[COORD_WIDTH-1:0]),
    .inv     (item.inv_dir_y[COORD_WIDTH-1:0]),
    .en      (lane_en),
    .near_t  (near_y),
    .far_t   (far_y),
    .in_slab (in_y)
  );

  rbst_axis_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_z (
    .clk     (clk),
    .lo      (item.box_min_z[COORD_WIDTH-1:0]),
    .hi      (item.box_max_z[COORD_WIDTH-1:0]),
    .org     (item.origin_z[COORD_WIDTH-1:0]),
    .inv     (item.inv_dir_z[COORD_WIDTH-1:0]),
    .en      (lane_en),
    .near_t  (near_z),
    .far_t   (far_z),
    .in_slab (in_z)
  );

  // Stage 4: merge the x and y axes, carry z along.
  always_ff @(posedge clk) begin
    if (r4) begin
      near01  <= (near_x > near_y) ? near_x : near_y;
      far01   <= (far_x < far_y) ? far_x : far_y;
      near2   <= near_z;
      far2    <= far_z;
      inside4 <= in_x && in_y && in_z;
    end
  end

  // Stage 5: merge in the z axis.
  always_ff @(posedge clk) begin
    if (r5) begin
      near5   <= (near01 > near2) ? near01 : near2;
      far5    <= (far01 < far2) ? far01 : far2;
      inside5 <= inside4;
    end
  end

  // Stage 6: the ray hits when the origin is inside or the far distance
  // is not below the near one.
  always_ff @(posedge clk) begin
    if (r6) begin
      result.hit           <= inside5 || (far5 >= near5);
      result.origin_inside <= inside5;
    end
  end

  // An origin inside the box always reports a hit.
  `RBST_ASSERT(a_inside_hits, clk, rst, result_valid |-> (result.hit || !result.origin_inside))

  // With the output stage empty, every stage behind it can take an item.
  `RBST_ASSERT(a_ready_when_empty, clk, rst, !result_valid |-> item_ready)

  // No result shows up in the cycle after reset.
  `RBST_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> !result_valid)

endmodule

// ===== sim/tb_ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// Ray box slab test testbench
// Drives box, origin and inverse direction items into the ray box slab test
// and checks every hit and origin_inside flag against an internal predictor
// of the slab method. A short set of directed items covers the field
// extremes, origins on and just off the box faces, inverted boxes, zero and
// saturated inverse directions. A long random stream follows. Both
// handshakes idle at random, and two long receiver stalls fill the pipeline.
// ----------------------------------------------------------------------------
module tb_ray_box_slab_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_ITEMS = 1200;
  localparam int S_MAX        = 32'sh7fff_ffff;
  localparam int S_MIN        = -32'sh7fff_ffff - 1;
  localparam int ONE          = 32'sh0001_0000;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  rbst_pkg::in_item_t  item;
  logic                result_valid;
  logic                result_ready;
  rbst_pkg::out_item_t result;

  // Flags predicted for accepted items, oldest first.
  rbst_pkg::out_item_t verdict_q[$];
  int                  fail_count;
  int                  cycle_count;

  // Idle control shared by the stimulus and the receiver.
  bit tx_no_idle;
  bit rx_no_idle;
  int rx_hold_cycles;

  ray_box_slab_test dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Clock with an 8 unit period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Slab method on exact 64-bit products of the signed coordinates.
  function automatic rbst_pkg::out_item_t slab_verdict(rbst_pkg::in_item_t it);
    longint              lo[3];
    longint              hi[3];
    longint              org[3];
    longint              inv[3];
    longint              t1;
    longint              t2;
    longint              near_t;
    longint              far_t;
    rbst_pkg::out_item_t v;
    lo[0]  = longint'(it.box_min_x);
    lo[1]  = longint'(it.box_min_y);
    lo[2]  = longint'(it.box_min_z);
    hi[0]  = longint'(it.box_max_x);
    hi[1]  = longint'(it.box_max_y);
    hi[2]  = longint'(it.box_max_z);
    org[0] = longint'(it.origin_x);
    org[1] = longint'(it.origin_y);
    org[2] = longint'(it.origin_z);
    inv[0] = longint'(it.inv_dir_x);
    inv[1] = longint'(it.inv_dir_y);
    inv[2] = longint'(it.inv_dir_z);
    v.origin_inside = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (org[a] > hi[a] || org[a] < lo[a]) begin
        v.origin_inside = 1'b0;
      end
    end
    near_t = 0;
    far_t  = 0;
    for (int a = 0; a < 3; a++) begin
      t1 = (lo[a] - org[a]) * inv[a];
      t2 = (hi[a] - org[a]) * inv[a];
      if (a == 0) begin
        near_t = (t1 < t2) ? t1 : t2;
        far_t  = (t1 < t2) ? t2 : t1;
      end else begin
        if (((t1 < t2) ? t1 : t2) > near_t) begin
          near_t = (t1 < t2) ? t1 : t2;
        end
        if (((t1 < t2) ? t2 : t1) < far_t) begin
          far_t = (t1 < t2) ? t2 : t1;
        end
      end
    end
    v.hit = v.origin_inside || (far_t >= near_t);
    return v;
  endfunction

  // Builds one item from box bounds, origin and inverse direction.
  function automatic rbst_pkg::in_item_t ray_box(int lx, int ly, int lz,
                                                 int hx, int hy, int hz,
                                                 int ox, int oy, int oz,
                                                 int ix, int iy, int iz);
    rbst_pkg::in_item_t it;
    it.box_min_x = lx;
    it.box_min_y = ly;
    it.box_min_z = lz;
    it.box_max_x = hx;
    it.box_max_y = hy;
    it.box_max_z = hz;
    it.origin_x  = ox;
    it.origin_y  = oy;
    it.origin_z  = oz;
    it.inv_dir_x = ix;
    it.inv_dir_y = iy;
    it.inv_dir_z = iz;
    return it;
  endfunction

  // Any 32-bit pattern, so every field bit toggles.
  function automatic int any_coord();
    return int'($urandom);
  endfunction

  // Inverse direction drawn from full range, zero, saturated or moderate values.
  function automatic int rand_inv_dir();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: begin
        return any_coord();
      end
      1: begin
        return 0;
      end
      2: begin
        return S_MAX;
      end
      3: begin
        return S_MIN;
      end
      default: begin
        return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      end
    endcase
  endfunction

  // Box around a random center, sometimes inverted, with the origin nearby, sometimes on a face.
  function automatic rbst_pkg::in_item_t rand_near_box();
    int c[3];
    int h[3];
    int lo[3];
    int hi[3];
    int org[3];
    int inv[3];
    int tmp;
    int sel;
    for (int a = 0; a < 3; a++) begin
      c[a]  = int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      h[a]  = int'($urandom_range(0, 32'h0010_0000));
      lo[a] = c[a] - h[a];
      hi[a] = c[a] + h[a];
      if ($urandom_range(0, 15) == 0) begin
        tmp   = lo[a];
        lo[a] = hi[a];
        hi[a] = tmp;
      end
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        org[a] = lo[a];
      end else if (sel == 1) begin
        org[a] = hi[a];
      end else begin
        org[a] = c[a] + int'($urandom_range(0, 6 * h[a] + 2)) - 3 * h[a] - 1;
      end
      inv[a] = rand_inv_dir();
    end
    return ray_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                   org[0], org[1], org[2], inv[0], inv[1], inv[2]);
  endfunction

  // Tiny coordinates so that faces, corners and ties come up often.
  function automatic rbst_pkg::in_item_t rand_tiny_box();
    int f[12];
    for (int k = 0; k < 12; k++) begin
      f[k] = int'($urandom_range(0, 15)) - 8;
    end
    return ray_box(f[0], f[1], f[2], f[3], f[4], f[5],
                   f[6], f[7], f[8], f[9], f[10], f[11]);
  endfunction

  // Offers one item after a random gap and holds it until it is accepted.
  task automatic send_item(rbst_pkg::in_item_t it);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) begin
      @(posedge clk);
    end
  endtask

  // Extremes of every field, including the largest plane distance products.
  task automatic test_field_extremes();
    send_item(ray_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(ray_box(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                      S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
    send_item(ray_box(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                      S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
    send_item(ray_box(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX,
                      S_MAX, S_MIN, 0, S_MAX, S_MIN, -1));
    send_item(ray_box(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                      S_MAX, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN));
    send_item(ray_box(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                      S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX));
    send_item(ray_box(-ONE, -ONE, -ONE, ONE, ONE, ONE,
                      S_MAX, 0, 0, S_MIN, S_MAX, S_MAX));
    send_item(ray_box(-1, -1, -1, -1, -1, -1, S_MAX, S_MIN, S_MAX, -1, -1, -1));
  endtask

  // Origins on the box faces count as inside; one step off does not.
  task automatic test_origin_on_faces();
    send_item(ray_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE));
    send_item(ray_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    send_item(ray_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, ONE + 1, 0, 0, 0, ONE, ONE));
    send_item(ray_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, -ONE - 1, 0, ONE, 0, ONE));
    send_item(ray_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, ONE + 1, ONE, ONE, S_MAX));
    // A box behind the origin still meets the line.
    send_item(ray_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE,
                      5 * ONE, 5 * ONE, 5 * ONE, ONE, ONE, ONE));
    // A line that passes beside the box.
    send_item(ray_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE,
                      0, 5 * ONE, 0, ONE, -ONE, ONE));
  endtask

  // Lower bound above upper bound: never inside, slab runs on the given bounds.
  task automatic test_inverted_box();
    send_item(ray_box(ONE, ONE, ONE, -ONE, -ONE, -ONE, 0, 0, 0, ONE, ONE, ONE));
    send_item(ray_box(ONE, -ONE, -ONE, -ONE, ONE, ONE, 0, 0, 0, ONE, -ONE, ONE));
    send_item(ray_box(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN,
                      0, 0, 0, S_MIN, S_MAX, 0));
  endtask

  // Zero inverse directions and saturated values for axis-parallel rays.
  task automatic test_zero_and_saturated_dir();
    send_item(ray_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0, 0, 0, 0));
    send_item(ray_box(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE,
                      0, 3 * ONE, 3 * ONE, 0, ONE, -ONE));
    send_item(ray_box(-ONE, -ONE, -ONE, ONE, ONE, ONE,
                      5 * ONE, 0, 0, S_MIN, S_MAX, S_MAX));
    send_item(ray_box(-ONE, -ONE, -ONE, ONE, ONE, ONE,
                      5 * ONE, 3 * ONE, 0, S_MIN, S_MAX, S_MAX));
    send_item(ray_box(-ONE, -ONE, -ONE, ONE, ONE, ONE,
                      0, 0, -5 * ONE, S_MAX, S_MAX, S_MAX));
  endtask

  // Mostly well-formed boxes with nearby origins, plus tiny boxes and noise.
  task automatic test_random_stream();
    int sel;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        tx_no_idle = ($urandom_range(0, 3) == 0);
        rx_no_idle = ($urandom_range(0, 3) == 0);
      end
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        send_item(rand_near_box());
      end else if (sel < 15) begin
        send_item(rand_tiny_box());
      end else begin
        send_item(ray_box(any_coord(), any_coord(), any_coord(), any_coord(),
                          any_coord(), any_coord(), any_coord(), any_coord(),
                          any_coord(), any_coord(), any_coord(), any_coord()));
      end
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // The receiver stops for a long stretch while items keep coming back to back.
  task automatic test_output_stall();
    tx_no_idle     = 1'b1;
    rx_hold_cycles = 150;
    for (int n = 0; n < 40; n++) begin
      send_item(rand_near_box());
    end
    tx_no_idle = 1'b0;
  endtask

  // Result side: a random wait before each item, and the long hold on request.
  initial begin
    int gap;
    result_ready = 1'b0;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      if (rx_hold_cycles > 0) begin
        gap            = rx_hold_cycles;
        rx_hold_cycles = 0;
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      gap = rx_no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) begin
        @(posedge clk);
      end
    end
  end

  // Record each accepted item's prediction and check each accepted result.
  always @(posedge clk) begin
    rbst_pkg::out_item_t want;
    if (!rst) begin
      if (item_valid && item_ready) begin
        verdict_q.push_back(slab_verdict(item));
      end
      if (result_valid && result_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result item with no accepted input waiting");
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (result.hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, result.hit);
            fail_count++;
          end
          if (result.origin_inside !== want.origin_inside) begin
            $error("origin_inside: expected %0b, actual %0b",
                   want.origin_inside, result.origin_inside);
            fail_count++;
          end
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Reset, the tests in turn, then drain and report.
  initial begin
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    fail_count     = 0;
    cycle_count    = 0;
    tx_no_idle     = 1'b0;
    rx_no_idle     = 1'b0;
    rx_hold_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_origin_on_faces();
    test_inverted_box();
    test_zero_and_saturated_dir();
    test_output_stall();
    test_random_stream();
    test_output_stall();
    item_valid <= 1'b0;
    while (verdict_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rbst_pkg.sv
rtl/core/rbst_axis_lane.sv
rtl/core/ray_box_slab_test.sv
sim/tb_ray_box_slab_test.sv
